// ===== src/cpcr_pkg.sv =====
// Shared widths, stage counts, register codes and beat types for the
// circle pair collision response pipeline. No dependencies.
package cpcr_pkg;

    // Field widths
    localparam int POS_W   = 24;
    localparam int RAD_W   = 23;
    localparam int MASS_W  = 24;
    localparam int BC_W    = 16;
    localparam int OUT_W   = 32;

    // Internal arithmetic widths
    localparam int DIFF_W   = POS_W + 1;
    localparam int SQR_W    = 2 * DIFF_W;
    localparam int ROOT_W   = RAD_W;
    localparam int RAD2_W   = 2 * ROOT_W;
    localparam int REL_W    = SQR_W + 1;
    localparam int RELM_W   = 49;
    localparam int DC_W     = RAD_W;
    localparam int REL_LO_W = 25;
    localparam int P1_W     = DC_W + RELM_W;
    localparam int BM_W     = BC_W + MASS_W;
    localparam int CH_A     = 24;
    localparam int CH_B     = 20;
    localparam int N_W      = P1_W + BM_W;
    localparam int VSHIFT   = 30;
    localparam int VNUM_W   = N_W - VSHIFT;
    localparam int VQ_W     = 32;
    localparam int PNUM_W   = 2 * ROOT_W;
    localparam int PDEN_W   = ROOT_W + 1;
    localparam int PQ_W     = 24;

    // Stage counts
    localparam int FRONT_LAT = 3;
    localparam int PUSH_LAT  = ROOT_W + 2 + PQ_W + 1;
    localparam int VMUL_LAT  = 5;
    localparam int VEL_LAT   = VMUL_LAT + VQ_W + 1 + 1;
    localparam int VEL_DLY   = PUSH_LAT - VEL_LAT;
    localparam int PIPE_LAT  = FRONT_LAT + PUSH_LAT + 1;

    // Register map
    localparam int         ADDR_W       = 3;
    localparam logic       REG_BOUNCE   = 1'b0;
    localparam logic [BC_W-1:0] BOUNCE_RESET = 16'd16384;

    // Saturation limits
    localparam logic [OUT_W-1:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG_MAG = 32'h8000_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic        [RAD_W-1:0] radius_sum;
        logic signed [POS_W-1:0] first_vx;
        logic signed [POS_W-1:0] first_vy;
        logic signed [POS_W-1:0] second_vx;
        logic signed [POS_W-1:0] second_vy;
        logic       [MASS_W-1:0] first_inv_mass;
        logic       [MASS_W-1:0] second_inv_mass;
    } t_in;

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] push_x;
        logic signed [OUT_W-1:0] push_y;
        logic signed [OUT_W-1:0] first_fix_x;
        logic signed [OUT_W-1:0] first_fix_y;
        logic signed [OUT_W-1:0] second_fix_x;
        logic signed [OUT_W-1:0] second_fix_y;
    } t_out;

    typedef struct packed {
        logic              hit;
        logic [RAD_W-1:0]  tgt;
        logic [DC_W-1:0]   dxm;
        logic [DC_W-1:0]   dym;
        logic              dx_neg;
        logic              dy_neg;
        logic              rel_neg;
        logic [RELM_W-1:0] relm;
        logic [RAD2_W-1:0] sqr;
        logic [BM_W-1:0]   bm1;
        logic [BM_W-1:0]   bm2;
    } t_front;

    typedef struct packed {
        logic            hit;
        logic            dx_neg;
        logic            dy_neg;
        logic [PQ_W-1:0] qx;
        logic [PQ_W-1:0] qy;
        logic            ovfx;
        logic            ovfy;
    } t_push;

    typedef struct packed {
        logic signed [OUT_W-1:0] f1x;
        logic signed [OUT_W-1:0] f1y;
        logic signed [OUT_W-1:0] f2x;
        logic signed [OUT_W-1:0] f2y;
    } t_fix;

endpackage

// ===== src/cpcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on cpcr_pkg for default widths.
module cpcr_div #(
    parameter int NUM_W = cpcr_pkg::VNUM_W,
    parameter int DEN_W = cpcr_pkg::RAD2_W,
    parameter int Q_W   = cpcr_pkg::VQ_W
) (
    input  logic             i_clk,
    input  logic [Q_W:0]     i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf
);
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]   r_lo  [Q_W+1];
    logic [Q_W-1:0]   r_q   [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic             r_ovf [Q_W+1];

    logic [CMP_W-1:0] w_hi;
    logic             w_ovf;

    // Flag a quotient that needs more than Q_W bits
    always_comb begin
        w_hi  = CMP_W'(i_num[NUM_W-1:Q_W]);
        w_ovf = w_hi >= CMP_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= w_hi[DEN_W-1:0];
            r_lo[0]  <= i_num[Q_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= w_ovf;
        end
    end

    // Shift in one dividend bit and subtract where it fits
    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DEN_W:0] w_sh;
        logic [DEN_W:0] w_df;
        logic           w_ge;

        always_comb begin
            w_sh = {r_rem[k-1], r_lo[k-1][Q_W-1]};
            w_df = w_sh - {1'b0, r_den[k-1]};
            w_ge = w_sh >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= w_ge ? w_df[DEN_W-1:0] : w_sh[DEN_W-1:0];
                r_lo[k]  <= {r_lo[k-1][Q_W-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][Q_W-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_q[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

// ===== src/cpcr_front.sv =====
// Front stages: separation, squares, relative velocity projection, hit test.
// Depends on cpcr_pkg.
module cpcr_front (
    input  logic                                 i_clk,
    input  logic [cpcr_pkg::FRONT_LAT-1:0]       i_en,
    input  cpcr_pkg::t_in                        i_in,
    input  logic [cpcr_pkg::BC_W-1:0]            i_bounce,
    output cpcr_pkg::t_front                     o_front
);
    import cpcr_pkg::*;

    logic signed [DIFF_W-1:0] r_dx0, r_dy0, r_dvx0, r_dvy0;
    logic [RAD_W-1:0]         r_tgt0;
    logic [MASS_W-1:0]        r_m1, r_m2;

    logic signed [SQR_W-1:0]  r_sx, r_sy, r_rx, r_ry;
    logic [RAD2_W-1:0]        r_tgt2;
    logic [BM_W-1:0]          r_bm1, r_bm2;
    logic signed [DIFF_W-1:0] r_dx1, r_dy1;
    logic [RAD_W-1:0]         r_tgt1;

    t_front                   r_front;

    logic [SQR_W-1:0]         w_sqr;
    logic signed [REL_W-1:0]  w_rel, w_rel_abs;
    logic signed [DIFF_W-1:0] w_dx_abs, w_dy_abs;

    // Stage 0: differences of positions and velocities
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dx0  <= {i_in.second_x[POS_W-1], i_in.second_x}
                    - {i_in.first_x[POS_W-1], i_in.first_x};
            r_dy0  <= {i_in.second_y[POS_W-1], i_in.second_y}
                    - {i_in.first_y[POS_W-1], i_in.first_y};
            r_dvx0 <= {i_in.first_vx[POS_W-1], i_in.first_vx}
                    - {i_in.second_vx[POS_W-1], i_in.second_vx};
            r_dvy0 <= {i_in.first_vy[POS_W-1], i_in.first_vy}
                    - {i_in.second_vy[POS_W-1], i_in.second_vy};
            r_tgt0 <= i_in.radius_sum;
            r_m1   <= i_in.first_inv_mass;
            r_m2   <= i_in.second_inv_mass;
        end
    end

    // Stage 1: one multiplier per product
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sx   <= r_dx0 * r_dx0;
            r_sy   <= r_dy0 * r_dy0;
            r_rx   <= r_dvx0 * r_dx0;
            r_ry   <= r_dvy0 * r_dy0;
            r_tgt2 <= r_tgt0 * r_tgt0;
            r_bm1  <= i_bounce * r_m1;
            r_bm2  <= i_bounce * r_m2;
            r_dx1  <= r_dx0;
            r_dy1  <= r_dy0;
            r_tgt1 <= r_tgt0;
        end
    end

    // Stage 2: sums, magnitudes and the hit test
    always_comb begin
        w_sqr     = unsigned'(r_sx) + unsigned'(r_sy);
        w_rel     = {r_rx[SQR_W-1], r_rx} + {r_ry[SQR_W-1], r_ry};
        w_rel_abs = w_rel[REL_W-1] ? -w_rel : w_rel;
        w_dx_abs  = r_dx1[DIFF_W-1] ? -r_dx1 : r_dx1;
        w_dy_abs  = r_dy1[DIFF_W-1] ? -r_dy1 : r_dy1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_front.hit     <= (w_sqr != '0) && (w_sqr < SQR_W'(r_tgt2));
            r_front.tgt     <= r_tgt1;
            r_front.dxm     <= w_dx_abs[DC_W-1:0];
            r_front.dym     <= w_dy_abs[DC_W-1:0];
            r_front.dx_neg  <= r_dx1[DIFF_W-1];
            r_front.dy_neg  <= r_dy1[DIFF_W-1];
            r_front.rel_neg <= w_rel[REL_W-1];
            r_front.relm    <= w_rel_abs[RELM_W-1:0];
            r_front.sqr     <= w_sqr[RAD2_W-1:0];
            r_front.bm1     <= r_bm1;
            r_front.bm2     <= r_bm2;
        end
    end

    assign o_front = r_front;

endmodule

// ===== src/cpcr_push.sv =====
// Push path: pipelined integer square root, gap scaling, push dividers.
// Depends on cpcr_pkg and cpcr_div.
module cpcr_push (
    input  logic                              i_clk,
    input  logic [cpcr_pkg::PUSH_LAT-1:0]     i_en,
    input  cpcr_pkg::t_front                  i_front,
    output cpcr_pkg::t_push                   o_push
);
    import cpcr_pkg::*;

    localparam int REM_W  = ROOT_W + 2;
    localparam int DIV0   = ROOT_W + 2;
    localparam int DIV_N  = PQ_W + 1;

    typedef struct packed {
        logic             hit;
        logic [RAD_W-1:0] tgt;
        logic [DC_W-1:0]  dxm;
        logic [DC_W-1:0]  dym;
        logic             dx_neg;
        logic             dy_neg;
    } t_side;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD2_W-1:0] r_rad  [ROOT_W];
    t_side             r_side [ROOT_W];

    logic [RAD_W-1:0]  r_gap;
    logic [PDEN_W-1:0] r_d2, r_den;
    t_side             r_sa, r_sb;
    logic [PNUM_W-1:0] r_nx, r_ny;
    logic [2:0]        r_flg [DIV_N];

    logic [PQ_W-1:0]   w_qx, w_qy;
    logic              w_ovfx, w_ovfy;

    // Square root, one result bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [RAD2_W-1:0] s_rad;
        t_side             s_side;
        logic [REM_W+1:0]  w_sh, w_trial, w_df;
        logic              w_ge;

        if (j == 0) begin : g_first
            always_comb begin
                s_rem         = '0;
                s_root        = '0;
                s_rad         = i_front.sqr;
                s_side.hit    = i_front.hit;
                s_side.tgt    = i_front.tgt;
                s_side.dxm    = i_front.dxm;
                s_side.dym    = i_front.dym;
                s_side.dx_neg = i_front.dx_neg;
                s_side.dy_neg = i_front.dy_neg;
            end
        end else begin : g_next
            always_comb begin
                s_rem  = r_rem[j-1];
                s_root = r_root[j-1];
                s_rad  = r_rad[j-1];
                s_side = r_side[j-1];
            end
        end

        always_comb begin
            w_sh    = {s_rem, s_rad[RAD2_W-1 -: 2]};
            w_trial = (REM_W+2)'({s_root, 2'b01});
            w_df    = w_sh - w_trial;
            w_ge    = w_sh >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j]  <= w_ge ? w_df[REM_W-1:0] : w_sh[REM_W-1:0];
                r_root[j] <= {s_root[ROOT_W-2:0], w_ge};
                r_rad[j]  <= {s_rad[RAD2_W-3:0], 2'b00};
                r_side[j] <= s_side;
            end
        end
    end

    // Gap to the radius sum and the doubled distance
    always_ff @(posedge i_clk) begin
        if (i_en[ROOT_W]) begin
            r_gap <= r_side[ROOT_W-1].tgt - r_root[ROOT_W-1];
            r_d2  <= {r_root[ROOT_W-1], 1'b0};
            r_sa  <= r_side[ROOT_W-1];
        end
    end

    // Scale each axis by the gap
    always_ff @(posedge i_clk) begin
        if (i_en[ROOT_W+1]) begin
            r_nx  <= r_sa.dxm * r_gap;
            r_ny  <= r_sa.dym * r_gap;
            r_den <= r_d2;
            r_sb  <= r_sa;
        end
    end

    cpcr_div #(.NUM_W(PNUM_W), .DEN_W(PDEN_W), .Q_W(PQ_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en[DIV0 +: DIV_N]),
        .i_num (r_nx),
        .i_den (r_den),
        .o_quo (w_qx),
        .o_ovf (w_ovfx)
    );

    cpcr_div #(.NUM_W(PNUM_W), .DEN_W(PDEN_W), .Q_W(PQ_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en[DIV0 +: DIV_N]),
        .i_num (r_ny),
        .i_den (r_den),
        .o_quo (w_qy),
        .o_ovf (w_ovfy)
    );

    // Carry hit and signs alongside the dividers
    for (genvar k = 0; k < DIV_N; k++) begin : g_flg
        always_ff @(posedge i_clk) begin
            if (i_en[DIV0+k]) begin
                if (k == 0) begin
                    r_flg[k] <= {r_sb.hit, r_sb.dx_neg, r_sb.dy_neg};
                end else begin
                    r_flg[k] <= r_flg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_comb begin
        o_push.hit    = r_flg[DIV_N-1][2];
        o_push.dx_neg = r_flg[DIV_N-1][1];
        o_push.dy_neg = r_flg[DIV_N-1][0];
        o_push.qx     = w_qx;
        o_push.qy     = w_qy;
        o_push.ovfx   = w_ovfx;
        o_push.ovfy   = w_ovfy;
    end

endmodule

// ===== src/cpcr_vel.sv =====
// Velocity correction path: wide product in partial products, four dividers
// by the squared distance, signed saturation. Depends on cpcr_pkg, cpcr_div.
module cpcr_vel (
    input  logic                             i_clk,
    input  logic [cpcr_pkg::VEL_LAT-1:0]     i_en,
    input  cpcr_pkg::t_front                 i_front,
    output cpcr_pkg::t_fix                   o_fix
);
    import cpcr_pkg::*;

    localparam int PA_LO_W = DC_W + REL_LO_W;
    localparam int PA_HI_W = DC_W + RELM_W - REL_LO_W;
    localparam int PP_W    = CH_A + CH_B;
    localparam int ROW_W   = P1_W + CH_B;
    localparam int NCH_A   = P1_W / CH_A;
    localparam int NCH_B   = BM_W / CH_B;
    localparam int DIV0    = VMUL_LAT;
    localparam int DIV_N   = VQ_W + 1;
    localparam int SAT_ST  = VMUL_LAT + VQ_W + 1;

    typedef struct packed {
        logic [BM_W-1:0]   bm1;
        logic [BM_W-1:0]   bm2;
        logic [RAD2_W-1:0] sqr;
        logic              negx;
        logic              negy;
    } t_vside;

    t_vside             r_vs    [VMUL_LAT];
    logic [PA_LO_W-1:0] r_pa_lo [2];
    logic [PA_HI_W-1:0] r_pa_hi [2];
    logic [P1_W-1:0]    r_p1    [2];
    logic [PP_W-1:0]    r_pp    [4][NCH_A][NCH_B];
    logic [ROW_W-1:0]   r_row   [4][NCH_B];
    logic [N_W-1:0]     r_n     [4];
    logic [1:0]         r_ng    [DIV_N];
    logic [OUT_W-1:0]   r_fix   [4];
    logic [DC_W-1:0]    w_dc    [2];
    logic [BM_W-1:0]    w_bm    [2];

    always_comb begin
        w_dc[0] = i_front.dxm;
        w_dc[1] = i_front.dym;
        w_bm[0] = r_vs[1].bm1;
        w_bm[1] = r_vs[1].bm2;
    end

    // Side data through the multiply stages
    for (genvar k = 0; k < VMUL_LAT; k++) begin : g_vs
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                if (k == 0) begin
                    r_vs[k].bm1  <= i_front.bm1;
                    r_vs[k].bm2  <= i_front.bm2;
                    r_vs[k].sqr  <= i_front.sqr;
                    r_vs[k].negx <= i_front.dx_neg ^ i_front.rel_neg;
                    r_vs[k].negy <= i_front.dy_neg ^ i_front.rel_neg;
                end else begin
                    r_vs[k] <= r_vs[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // Axis magnitude times relative speed, in two halves, then joined
    for (genvar a = 0; a < 2; a++) begin : g_axis
        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_pa_lo[a] <= w_dc[a] * i_front.relm[REL_LO_W-1:0];
                r_pa_hi[a] <= w_dc[a] * i_front.relm[RELM_W-1:REL_LO_W];
            end
            if (i_en[1]) begin
                r_p1[a] <= P1_W'(r_pa_lo[a]) + (P1_W'(r_pa_hi[a]) << REL_LO_W);
            end
        end
    end

    // Four lanes: first mass x/y, second mass x/y
    for (genvar l = 0; l < 4; l++) begin : g_lane
        localparam int AX = l % 2;
        localparam int MS = l / 2;
        logic [ROW_W-1:0] w_row [NCH_B];
        logic             w_neg;
        logic [OUT_W-1:0] w_q;
        logic             w_ovf;
        logic [OUT_W-1:0] w_mag;

        for (genvar i = 0; i < NCH_A; i++) begin : g_pa
            for (genvar j = 0; j < NCH_B; j++) begin : g_pb
                always_ff @(posedge i_clk) begin
                    if (i_en[2]) begin
                        r_pp[l][i][j] <= r_p1[AX][CH_A*i +: CH_A]
                                       * w_bm[MS][CH_B*j +: CH_B];
                    end
                end
            end
        end

        // Sum each row of partial products
        always_comb begin
            for (int j = 0; j < NCH_B; j++) begin
                w_row[j] = '0;
                for (int i = 0; i < NCH_A; i++) begin
                    w_row[j] = w_row[j] + (ROW_W'(r_pp[l][i][j]) << (CH_A * i));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[3]) begin
                for (int j = 0; j < NCH_B; j++) begin
                    r_row[l][j] <= w_row[j];
                end
            end
            if (i_en[4]) begin
                r_n[l] <= N_W'(r_row[l][0]) + (N_W'(r_row[l][1]) << CH_B);
            end
        end

        cpcr_div #(.NUM_W(VNUM_W), .DEN_W(RAD2_W), .Q_W(VQ_W)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en[DIV0 +: DIV_N]),
            .i_num (r_n[l][N_W-1:VSHIFT]),
            .i_den (r_vs[VMUL_LAT-1].sqr),
            .o_quo (w_q),
            .o_ovf (w_ovf)
        );

        // Clamp the magnitude, then apply the sign
        always_comb begin
            w_neg = r_ng[DIV_N-1][AX];
            if (w_neg) begin
                w_mag = (w_ovf || (w_q > SAT_NEG_MAG)) ? SAT_NEG_MAG : w_q;
            end else begin
                w_mag = (w_ovf || w_q[OUT_W-1]) ? SAT_POS : w_q;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[SAT_ST]) begin
                r_fix[l] <= w_neg ? (OUT_W'(0) - w_mag) : w_mag;
            end
        end
    end

    // Signs alongside the dividers (bit 0 for x, bit 1 for y)
    for (genvar k = 0; k < DIV_N; k++) begin : g_ng
        always_ff @(posedge i_clk) begin
            if (i_en[DIV0+k]) begin
                if (k == 0) begin
                    r_ng[k] <= {r_vs[VMUL_LAT-1].negy, r_vs[VMUL_LAT-1].negx};
                end else begin
                    r_ng[k] <= r_ng[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_comb begin
        o_fix.f1x = r_fix[0];
        o_fix.f1y = r_fix[1];
        o_fix.f2x = r_fix[2];
        o_fix.f2y = r_fix[3];
    end

endmodule

// ===== src/circle_pair_collision_response.sv =====
// Top level of the circle pair collision response pipeline: APB register,
// stage valid and stall control, path alignment and result register.
// Depends on cpcr_pkg, cpcr_front, cpcr_push, cpcr_vel.
//
// Takes one particle pair per clock while o_in_ready is high and returns one
// result beat per pair, in order. The pipeline has 54 register stages
// and its depth is set by the push path: three front stages, a 23-stage
// square root of the squared distance, two scaling stages, a 25-stage
// divider for the push and the result register. The velocity
// corrections run in parallel through a 39-stage multiply, divide and
// saturate path and are delayed to meet the push path. Each stage holds its
// own valid bit and advances whenever the stage ahead can take its beat, so
// empty slots let new pairs enter while a finished result waits.
// bounce_coef sits at byte address 0, resets to 1.0 in Q2.14, and is meant
// to change only while the pipeline is empty.
module circle_pair_collision_response (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpcr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cpcr_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cpcr_pkg::t_out                o_out_data
);
    import cpcr_pkg::*;

    localparam int PUSH0 = FRONT_LAT;
    localparam int VDLY0 = FRONT_LAT + VEL_LAT;
    localparam int LAST  = PIPE_LAT - 1;

    logic [BC_W-1:0]     r_bounce;
    logic [PIPE_LAT-1:0] r_vld;
    logic [PIPE_LAT-1:0] w_en;
    t_front              w_front;
    t_push               w_push;
    t_fix                w_fix;
    t_fix                r_vdly [VEL_DLY];
    t_out                r_out, n_out;
    logic [OUT_W-1:0]    w_pmx, w_pmy;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce <= BOUNCE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BOUNCE)) begin
            r_bounce <= pwdata[BC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BOUNCE) ? 32'(r_bounce) : '0;

    // Stage enables: a stage loads when it is empty or the stage ahead loads
    for (genvar k = 0; k < PIPE_LAT; k++) begin : g_en
        assign w_en[k] = i_out_ready | ~(&r_vld[PIPE_LAT-1:k]);
    end

    assign o_in_ready = w_en[0];

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    cpcr_front u_front (
        .i_clk    (i_clk),
        .i_en     (w_en[FRONT_LAT-1:0]),
        .i_in     (i_in_data),
        .i_bounce (r_bounce),
        .o_front  (w_front)
    );

    cpcr_push u_push (
        .i_clk   (i_clk),
        .i_en    (w_en[PUSH0 +: PUSH_LAT]),
        .i_front (w_front),
        .o_push  (w_push)
    );

    cpcr_vel u_vel (
        .i_clk   (i_clk),
        .i_en    (w_en[PUSH0 +: VEL_LAT]),
        .i_front (w_front),
        .o_fix   (w_fix)
    );

    // Delay the velocity corrections to meet the push path
    for (genvar k = 0; k < VEL_DLY; k++) begin : g_vdly
        always_ff @(posedge i_clk) begin
            if (w_en[VDLY0+k]) begin
                if (k == 0) begin
                    r_vdly[k] <= w_fix;
                end else begin
                    r_vdly[k] <= r_vdly[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // Sign the push and drop everything on a miss
    always_comb begin
        w_pmx = w_push.ovfx ? SAT_POS : OUT_W'(w_push.qx);
        w_pmy = w_push.ovfy ? SAT_POS : OUT_W'(w_push.qy);
        n_out = '0;
        if (w_push.hit) begin
            n_out.hit          = 1'b1;
            n_out.push_x       = w_push.dx_neg ? w_pmx : (OUT_W'(0) - w_pmx);
            n_out.push_y       = w_push.dy_neg ? w_pmy : (OUT_W'(0) - w_pmy);
            n_out.first_fix_x  = r_vdly[VEL_DLY-1].f1x;
            n_out.first_fix_y  = r_vdly[VEL_DLY-1].f1y;
            n_out.second_fix_x = r_vdly[VEL_DLY-1].f2x;
            n_out.second_fix_y = r_vdly[VEL_DLY-1].f2y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[LAST];
    assign o_out_data  = r_out;

`ifndef SYNTH
    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |->
            (o_out_data.push_x == '0) && (o_out_data.push_y == '0) &&
            (o_out_data.first_fix_x == '0) && (o_out_data.first_fix_y == '0) &&
            (o_out_data.second_fix_x == '0) && (o_out_data.second_fix_y == '0))
        else $error("miss result with nonzero fields");

    // Input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_vld) && !i_out_ready))
        else $error("input stalled with a free stage");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && (r_vld == '0)))
        else $error("valid beat right after reset");

    // A held result beat keeps its stage valid
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && !w_en[LAST]) |=> r_vld[LAST])
        else $error("held result beat lost");
`endif

endmodule

// ===== tb/sv/circle_pair_collision_response_tb.sv =====
// Self-checking testbench for circle_pair_collision_response: it drives pairs
// and APB writes and compares each result beat with a local fixed-point model.
// Depends on cpcr_pkg and the circle_pair_collision_response RTL.
module circle_pair_collision_response_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpcr_pkg::*;

    localparam int DRAIN_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;

    // Local copy of the bounce register and the queue of predicted responses
    logic [BC_W-1:0] bounce_now = BOUNCE_RESET;
    t_out            response_q[$];
    int              error_cnt = 0;
    bit              quiet = 1'b0;
    int              hold_cycles = 0;

    circle_pair_collision_response dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Floor of the square root, one result bit per pass
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
        if (v > 64'sd2147483647) return SAT_POS;
        if (v < -64'sd2147483648) return SAT_NEG_MAG;
        return v[OUT_W-1:0];
    endfunction

    // Velocity correction: exact 128-bit magnitude, truncate, then saturate
    function automatic logic signed [OUT_W-1:0] vel_fix(longint dc, longint rel,
            longint unsigned sqr, logic [MASS_W-1:0] inv_mass);
        logic [127:0] prod;
        logic [127:0] mag;
        longint unsigned dcm;
        longint unsigned relm;
        if (dc == 0 || rel == 0) return '0;
        dcm  = (dc < 0) ? -dc : dc;
        relm = (rel < 0) ? -rel : rel;
        prod = 128'(relm) * 128'(inv_mass) * 128'(bounce_now) * 128'(dcm);
        mag  = (prod / 128'(sqr)) >> VSHIFT;
        if ((dc < 0) != (rel < 0)) begin
            if (mag > 128'h8000_0000) mag = 128'h8000_0000;
            return -mag[OUT_W-1:0];
        end
        if (mag > 128'h7FFF_FFFF) mag = 128'h7FFF_FFFF;
        return mag[OUT_W-1:0];
    endfunction

    function automatic t_out predict_response(t_in p);
        t_out r;
        longint dx, dy, tgt, d, gap, rel;
        longint unsigned sqr;
        r   = '0;
        dx  = longint'(p.second_x) - longint'(p.first_x);
        dy  = longint'(p.second_y) - longint'(p.first_y);
        tgt = longint'(p.radius_sum);
        sqr = dx * dx + dy * dy;
        if (sqr > 0 && sqr < tgt * tgt) begin
            d   = root_floor(sqr);
            gap = d - tgt;
            rel = (longint'(p.first_vx) - longint'(p.second_vx)) * dx
                + (longint'(p.first_vy) - longint'(p.second_vy)) * dy;
            r.hit          = 1'b1;
            r.push_x       = clamp_out((dx * gap) / (2 * d));
            r.push_y       = clamp_out((dy * gap) / (2 * d));
            r.first_fix_x  = vel_fix(dx, rel, sqr, p.first_inv_mass);
            r.first_fix_y  = vel_fix(dy, rel, sqr, p.first_inv_mass);
            r.second_fix_x = vel_fix(dx, rel, sqr, p.second_inv_mass);
            r.second_fix_y = vel_fix(dy, rel, sqr, p.second_inv_mass);
        end
        return r;
    endfunction

    // Send one pair beat; then, unless quiet is set, leave the input idle at random
    task automatic send_pair(t_in p);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        response_q.insert(response_q.size(), predict_response(p));
        @(negedge i_clk);
        if (!quiet) begin
            while ($urandom_range(99) < 21) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (response_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_bounce(logic [BC_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * REG_BOUNCE);
        pwdata  <= {16'($urandom()), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        bounce_now = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_in random_pair();
        t_in p;
        logic [9*32-1:0] raw;
        int rs, k;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom()};
        p = raw[$bits(t_in)-1:0];
        // Most pairs are placed near each other so the hit path is exercised
        if ($urandom_range(99) < 75) begin
            k  = $urandom_range(22, 1);
            rs = $urandom_range((1 << k), 1);
            p.radius_sum = RAD_W'(rs);
            p.second_x = p.first_x + POS_W'($urandom_range(2 * rs) - rs);
            p.second_y = p.first_y + POS_W'($urandom_range(2 * rs) - rs);
            if ($urandom_range(3) == 0) begin
                p.first_vx  = POS_W'(int'($urandom_range(8192)) - 4096);
                p.second_vy = POS_W'(int'($urandom_range(8192)) - 4096);
            end
        end
        return p;
    endfunction

    task automatic test_directed();
        t_in p;
        // Fully extreme fields, both signs
        p = '1;
        send_pair(p);
        p = '0;
        send_pair(p);
        p = {POS_W'(24'h800000), POS_W'(24'h800000), POS_W'(24'h7FFFFF),
             POS_W'(24'h7FFFFF), RAD_W'(23'h7FFFFF), POS_W'(24'h7FFFFF),
             POS_W'(24'h800000), POS_W'(24'h800000), POS_W'(24'h7FFFFF),
             MASS_W'(24'hFFFFFF), MASS_W'(24'hFFFFFF)};
        send_pair(p);
        // Coincident centers: zero distance never hits
        p = '0;
        p.radius_sum = 23'd4096;
        p.first_vx = 24'sd1000;
        send_pair(p);
        // Distance exactly equal to the radius sum is no hit
        p.second_x = 24'sd4096;
        send_pair(p);
        // One LSB below the radius sum, and one LSB apart
        p.second_x = 24'sd4095;
        send_pair(p);
        p.second_x = 24'sd1;
        p.first_inv_mass = '1;
        p.second_inv_mass = 24'h010000;
        send_pair(p);
        // Tiny separation with huge closing speed saturates the corrections
        p = '0;
        p.second_y = -24'sd1;
        p.radius_sum = '1;
        p.first_vy = 24'sh7FFFFF;
        p.second_vy = 24'sh800000;
        p.first_inv_mass = '1;
        p.second_inv_mass = '1;
        send_pair(p);
        p.first_vy = 24'sh800000;
        p.second_vy = 24'sh7FFFFF;
        send_pair(p);
        // Diagonal overlap, separating and approaching, zero radius sum
        p = '0;
        p.first_x = -24'sd300000;
        p.second_x = -24'sd290000;
        p.second_y = 24'sd7000;
        p.radius_sum = 23'd20000;
        p.first_vx = 24'sd5000;
        p.second_vy = -24'sd3000;
        p.first_inv_mass = 24'd65536;
        p.second_inv_mass = 24'd32768;
        send_pair(p);
        p.first_vx = -24'sd5000;
        send_pair(p);
        p.radius_sum = '0;
        send_pair(p);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            // A stretch without idling on either side
            quiet = (i >= count / 3 && i < count / 3 + 120);
            send_pair(random_pair());
        end
        quiet = 1'b0;
    endtask

    // Stall the output long enough that the pipeline fills and backs up
    task automatic test_backpressure();
        hold_cycles = 200;
        quiet = 1'b1;
        for (int i = 0; i < 150; i++) send_pair(random_pair());
        quiet = 1'b0;
    endtask

    // Output ready: random idling, or a counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (quiet) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 21);
        end
    end

    task automatic check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            error_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(exp_v), $signed(act_v));
        end
    endtask

    // Compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (response_q.size() == 0) begin
                error_cnt++;
                $display("%0t ns: unexpected result beat, expected none, got %h",
                         $time, o_out_data);
            end else begin
                want = response_q.pop_front();
                check_field("hit", OUT_W'(want.hit), OUT_W'(o_out_data.hit));
                check_field("push_x", want.push_x, o_out_data.push_x);
                check_field("push_y", want.push_y, o_out_data.push_y);
                check_field("first_fix_x", want.first_fix_x, o_out_data.first_fix_x);
                check_field("first_fix_y", want.first_fix_y, o_out_data.first_fix_y);
                check_field("second_fix_x", want.second_fix_x, o_out_data.second_fix_x);
                check_field("second_fix_y", want.second_fix_y, o_out_data.second_fix_y);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(300);
        wait_idle();
        write_bounce(16'd0);
        test_directed();
        test_random(200);
        wait_idle();
        write_bounce(16'hFFFF);
        test_directed();
        test_random(300);
        test_backpressure();
        wait_idle();
        write_bounce(BC_W'($urandom()));
        test_random(300);
        wait_idle();
        write_bounce(BOUNCE_RESET);
        test_random(300);
        wait_idle();
        if (error_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
